FILE: sv/aot_pkg.sv
// Package with constants, state codes and helper functions of the odometry tracker.
`default_nettype none
package aot_pkg;

  localparam logic [31:0] TravelK   = 32'd37480660;
  localparam logic [31:0] HalfPi    = 32'd1686629713;
  localparam logic [31:0] QuarterPi = 32'd843314856;
  localparam logic [31:0] OneQ30    = 32'd1073741824;
  localparam logic [31:0] NMagic    = 32'd1367130551;
  localparam logic [15:0] DiamReset = 16'd11264;
  localparam logic [3:0]  SinLast   = 4'd4;
  localparam logic [3:0]  CosFirst  = 4'd5;
  localparam logic [3:0]  CosLast   = 4'd10;

  typedef enum logic [25:0] {
    StIdle  = 26'h0000001,
    StTr0   = 26'h0000002,
    StTr1   = 26'h0000004,
    StTr2   = 26'h0000008,
    StTr3   = 26'h0000010,
    StDelta = 26'h0000020,
    StSc0   = 26'h0000040,
    StSc1   = 26'h0000080,
    StSc2   = 26'h0000100,
    StSc3   = 26'h0000200,
    StSl0   = 26'h0000400,
    StSl1   = 26'h0000800,
    StSl2   = 26'h0001000,
    StSf0   = 26'h0002000,
    StSf1   = 26'h0004000,
    StSmap  = 26'h0008000,
    StCh0   = 26'h0010000,
    StCh1   = 26'h0020000,
    StCh2   = 26'h0040000,
    StUp0   = 26'h0080000,
    StUp1   = 26'h0100000,
    StUp2   = 26'h0200000,
    StUp3   = 26'h0400000,
    StUp4   = 26'h0800000,
    StDone  = 26'h1000000,
    StScQ   = 26'h2000000
  } state_e;

  function automatic logic [31:0] abs32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] apply_sign(logic [31:0] m, logic neg);
    return neg ? (~m + 32'd1) : m;
  endfunction

  // Rounds a Q30 product magnitude half up.
  function automatic logic [33:0] round_q30(logic [63:0] p);
    logic [63:0] s;
    s = p + 64'h0000_0000_2000_0000;
    return s[63:30];
  endfunction

  // Reciprocals of the series divisors, sine terms first, then cosine terms.
  // Each is the ceiling of 2^s / d, exact for dividends below 2^30.
  function automatic logic [31:0] series_magic(logic [3:0] j);
    logic [31:0] m;
    case (j)
      4'd0:    m = 32'd1249445032;
      4'd1:    m = 32'd1908874354;
      4'd2:    m = 32'd1636178018;
      4'd3:    m = 32'd1717986919;
      4'd4:    m = 32'd1431655766;
      4'd5:    m = 32'd2082408386;
      4'd6:    m = 32'd1527099484;
      4'd7:    m = 32'd1227133514;
      4'd8:    m = 32'd1145324613;
      4'd9:    m = 32'd1431655766;
      4'd10:   m = 32'd2147483648;
      default: m = 32'd1;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] series_shift(logic [3:0] j);
    logic [5:0] s;
    case (j)
      4'd0:    s = 6'd37;
      4'd1:    s = 6'd37;
      4'd2:    s = 6'd36;
      4'd3:    s = 6'd35;
      4'd4:    s = 6'd33;
      4'd5:    s = 6'd38;
      4'd6:    s = 6'd37;
      4'd7:    s = 6'd36;
      4'd8:    s = 6'd35;
      4'd9:    s = 6'd34;
      4'd10:   s = 6'd32;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: sv/aot_in_if.sv
// Sample channel carrying the wheel angles and the heading.
`default_nettype none
interface aot_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] parallel_wheel_angle;
  logic signed [31:0] side_wheel_angle;
  logic signed [31:0] heading;

  modport source (output valid, parallel_wheel_angle, side_wheel_angle, heading, input ready);
  modport sink   (input valid, parallel_wheel_angle, side_wheel_angle, heading, output ready);
endinterface
`default_nettype wire

FILE: sv/aot_out_if.sv
// Result channel carrying the global position.
`default_nettype none
interface aot_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;

  modport source (output valid, pos_x, pos_y, input ready);
  modport sink   (input valid, pos_x, pos_y, output ready);
endinterface
`default_nettype wire

FILE: sv/aot_mul.sv
// Shared 32 by 32 bit unsigned multiplier with a registered product.
`default_nettype none
module aot_mul (
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [63:0] prod_o
);
  logic [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= {32'd0, a_i} * {32'd0, b_i};
  end

  assign prod_o = prod_q;
endmodule
`default_nettype wire

FILE: sv/aot_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
`default_nettype none
module aot_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [63:0] den_i,
  output logic             busy_o,
  output logic      [63:0] quot_o
);
  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [63:0] rem_q;
  logic [63:0] qn_q;
  logic [63:0] den_q;
  logic [64:0] shifted;
  logic        fits;

  assign shifted = {rem_q, qn_q[63]};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= 64'd0;
      qn_q  <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? 64'(shifted - {1'b0, den_q}) : shifted[63:0];
      qn_q  <= {qn_q[62:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = qn_q;
endmodule
`default_nettype wire

FILE: sv/arc_odometry_tracker.sv
// Top level of the arc odometry tracker: sequencer and datapath around a shared multiplier
// and divider.
//
//   Channel    Direction  Handshake        Payload
//   sample_i   in         valid / ready    parallel_wheel_angle, side_wheel_angle, heading
//   result_o   out        valid / ready    pos_x, pos_y
//   cfg        in         cfg_we_i         cfg_wdata_i (wheel diameter)
//
// When the heading changed, a request runs an extra sine and cosine evaluation and two chord
// divisions. Each sine and cosine evaluation runs on the shared multiplier, and each of the
// two chord divisions holds the shared divider until its quotient is complete.
// Reset clears the position and the previous sample and loads the default diameter.
// A new request is taken while a result waits; the sequencer holds at its end until the
// output register is free.
`default_nettype none
module arc_odometry_tracker
  import aot_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  [15:0] cfg_wdata_i,
  aot_in_if.sink     sample_i,
  aot_out_if.source  result_o
);
  state_e state_q, state_d;

  logic [15:0] diam_q;
  logic [31:0] par_q, side_q, head_q;
  logic        wsel_q, cw_q, call_q, nneg_q, mneg_q;
  logic [15:0] ph_q;
  logic [31:0] low_q, tp_q, ts_q;
  logic [31:0] last_p_q, last_s_q, last_h_q;
  logic [31:0] dp_q, ds_q, dth_q;
  logic [38:0] x_q;
  logic [9:0]  n_q;
  logic [8:0]  q0_q;
  logic [39:0] tnum_q, nhp_q;
  logic [31:0] r_q, r2_q, y_q, sres_q, si_q, sp_q, cp_q, h_q, h2_q;
  logic [3:0]  j_q;
  logic [31:0] acc_x_q, acc_y_q, pos_x_q, pos_y_q;
  logic        res_valid_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        div_start, div_busy;
  logic [63:0] div_num, div_den, div_q;

  logic [31:0] cur_angle, mag32, dth_now, chord_d, rnd32, cur_h, cur_t;
  logic [39:0] t40, tnum, r40, rem40;
  logic [33:0] rnd;
  logic [63:0] sq;
  logic [8:0]  nmag;
  logic        nfix;
  logic        load_out;

  aot_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  aot_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (div_q)
  );

  assign cur_angle = wsel_q ? side_q : par_q;
  assign mag32     = low_q + prod[31:0];
  assign dth_now   = head_q - last_h_q;
  assign chord_d   = cw_q ? ds_q : dp_q;
  assign rnd       = round_q30(prod);
  assign rnd32     = rnd[31:0];
  assign t40       = {x_q[38], x_q} + {8'd0, QuarterPi};
  assign tnum      = t40[39] ? (~t40 + 40'd1 + {8'd0, HalfPi} - 40'd1) : t40;
  assign rem40     = tnum_q - prod[39:0];
  assign nfix      = rem40 >= {8'd0, HalfPi};
  assign nmag      = q0_q + {8'd0, nfix};
  assign r40       = nneg_q ? ({x_q[38], x_q} + nhp_q) : ({x_q[38], x_q} - nhp_q);
  assign sq        = prod >> series_shift(j_q);
  assign cur_h     = (state_q == StUp0 || state_q == StUp1) ? h_q : h2_q;
  assign cur_t     = (state_q == StUp0 || state_q == StUp3) ? cp_q : sp_q;
  assign load_out  = (state_q == StDone) && (!res_valid_q || result_o.ready);

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_q)
      StTr0: begin
        mul_a = abs32(cur_angle);
        mul_b = {16'd0, diam_q};
      end
      StTr1: begin
        mul_a = prod[31:0];
        mul_b = TravelK;
      end
      StTr2: begin
        mul_a = {16'd0, ph_q};
        mul_b = TravelK;
      end
      StSc0: begin
        mul_a = tnum[37:6];
        mul_b = NMagic;
      end
      StSc1: begin
        mul_a = {23'd0, prod[63:55]};
        mul_b = HalfPi;
      end
      StSc2: begin
        mul_a = abs32(r40[31:0]);
        mul_b = abs32(r40[31:0]);
      end
      StSl0: begin
        mul_a = r2_q;
        mul_b = abs32(y_q);
      end
      StSl1: begin
        mul_a = rnd32;
        mul_b = series_magic(j_q);
      end
      StSf0: begin
        mul_a = abs32(r_q);
        mul_b = abs32(y_q);
      end
      StCh0: begin
        mul_a = abs32(chord_d);
        mul_b = abs32(si_q);
      end
      StUp0, StUp1, StUp2, StUp3: begin
        mul_a = abs32(cur_h);
        mul_b = abs32(cur_t);
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = 64'd0;
    div_den   = 64'd1;
    unique case (state_q)
      StCh1: begin
        div_start = 1'b1;
        div_num   = {prod[62:0], 1'b0};
        div_den   = {26'd0, abs32(dth_q), 6'd0};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (sample_i.valid) state_d = StTr0;
      StTr0:   state_d = StTr1;
      StTr1:   state_d = StTr2;
      StTr2:   state_d = StTr3;
      StTr3:   state_d = wsel_q ? StDelta : StTr0;
      StDelta: state_d = StSc0;
      StSc0:   state_d = StSc1;
      StSc1:   state_d = StScQ;
      StScQ:   state_d = StSc2;
      StSc2:   state_d = StSc3;
      StSc3:   state_d = StSl0;
      StSl0:   state_d = StSl1;
      StSl1:   state_d = StSl2;
      StSl2: begin
        if (j_q == SinLast) begin
          state_d = StSf0;
        end else if (j_q == CosLast) begin
          state_d = StSmap;
        end else begin
          state_d = StSl0;
        end
      end
      StSf0:   state_d = StSf1;
      StSf1:   state_d = StSl0;
      StSmap:  state_d = call_q ? StUp0 : StCh0;
      StCh0:   state_d = StCh1;
      StCh1:   state_d = StCh2;
      StCh2: begin
        if (!div_busy) state_d = cw_q ? StSc0 : StCh0;
      end
      StUp0:   state_d = StUp1;
      StUp1:   state_d = StUp2;
      StUp2:   state_d = StUp3;
      StUp3:   state_d = StUp4;
      StUp4:   state_d = StDone;
      StDone:  if (load_out) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      res_valid_q <= 1'b0;
      diam_q      <= DiamReset;
      last_p_q    <= 32'd0;
      last_s_q    <= 32'd0;
      last_h_q    <= 32'd0;
      acc_x_q     <= 32'd0;
      acc_y_q     <= 32'd0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= load_out || (res_valid_q && !result_o.ready);
      if (cfg_we_i) begin
        diam_q <= cfg_wdata_i;
      end
      if (state_q == StDelta) begin
        last_p_q <= tp_q;
        last_s_q <= ts_q;
        last_h_q <= head_q;
      end
      unique case (state_q)
        StUp1:   acc_y_q <= acc_y_q + apply_sign(rnd32, h_q[31] ^ cp_q[31]);
        StUp2:   acc_x_q <= acc_x_q + apply_sign(rnd32, h_q[31] ^ sp_q[31]);
        StUp3:   acc_y_q <= acc_y_q - apply_sign(rnd32, h2_q[31] ^ sp_q[31]);
        StUp4:   acc_x_q <= acc_x_q + apply_sign(rnd32, h2_q[31] ^ cp_q[31]);
        default: acc_x_q <= acc_x_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pos_x_q <= acc_x_q;
      pos_y_q <= acc_y_q;
    end
    unique case (state_q)
      StIdle: begin
        par_q  <= sample_i.parallel_wheel_angle;
        side_q <= sample_i.side_wheel_angle;
        head_q <= sample_i.heading;
        wsel_q <= 1'b0;
      end
      StTr1: ph_q  <= prod[47:32];
      StTr2: begin
        low_q <= 32'((prod + 64'h0000_0000_8000_0000) >> 32);
      end
      StTr3: begin
        if (wsel_q) begin
          ts_q <= cur_angle[31] ? mag32 : (~mag32 + 32'd1);
        end else begin
          tp_q <= cur_angle[31] ? mag32 : (~mag32 + 32'd1);
        end
        wsel_q <= 1'b1;
      end
      StDelta: begin
        dp_q  <= tp_q - last_p_q;
        ds_q  <= ts_q - last_s_q;
        dth_q <= dth_now;
        if (dth_now != 32'd0) begin
          x_q    <= {{2{dth_now[31]}}, dth_now, 5'd0};
          call_q <= 1'b0;
        end else begin
          h_q    <= tp_q - last_p_q;
          h2_q   <= ts_q - last_s_q;
          x_q    <= {head_q[31], head_q, 6'd0};
          call_q <= 1'b1;
        end
      end
      StSc0: begin
        nneg_q <= t40[39];
        tnum_q <= tnum;
      end
      StSc1: q0_q <= prod[63:55];
      StScQ: begin
        n_q   <= nneg_q ? (~{1'b0, nmag} + 10'd1) : {1'b0, nmag};
        nhp_q <= prod[39:0] + (nfix ? {8'd0, HalfPi} : 40'd0);
      end
      StSc2: r_q    <= r40[31:0];
      StSc3: begin
        r2_q <= rnd32;
        y_q  <= OneQ30;
        j_q  <= 4'd0;
      end
      StSl1: mneg_q <= y_q[31];
      StSl2: begin
        y_q <= OneQ30 - apply_sign(sq[31:0], mneg_q);
        j_q <= j_q + 4'd1;
      end
      StSf1: begin
        sres_q <= apply_sign(rnd32, r_q[31] ^ y_q[31]);
        y_q    <= OneQ30;
        j_q    <= CosFirst;
      end
      StSmap: begin
        case (n_q[1:0])
          2'd0: begin
            si_q <= sres_q;
            sp_q <= sres_q;
            cp_q <= y_q;
          end
          2'd1: begin
            si_q <= y_q;
            sp_q <= y_q;
            cp_q <= ~sres_q + 32'd1;
          end
          2'd2: begin
            si_q <= ~sres_q + 32'd1;
            sp_q <= ~sres_q + 32'd1;
            cp_q <= ~y_q + 32'd1;
          end
          default: begin
            si_q <= ~y_q + 32'd1;
            sp_q <= ~y_q + 32'd1;
            cp_q <= sres_q;
          end
        endcase
        cw_q <= 1'b0;
      end
      StCh2: begin
        if (!div_busy) begin
          if (cw_q) begin
            h2_q   <= apply_sign(div_q[31:0], chord_d[31] ^ si_q[31] ^ dth_q[31]);
            x_q    <= {{2{dth_q[31]}}, dth_q, 5'd0} + {head_q[31], head_q, 6'd0};
            call_q <= 1'b1;
          end else begin
            h_q <= apply_sign(div_q[31:0], chord_d[31] ^ si_q[31] ^ dth_q[31]);
          end
          cw_q <= 1'b1;
        end
      end
      default: begin
        call_q <= call_q;
      end
    endcase
  end

  assign sample_i.ready = (state_q == StIdle);
  assign result_o.valid = res_valid_q;
  assign result_o.pos_x = pos_x_q;
  assign result_o.pos_y = pos_y_q;
endmodule
`default_nettype wire
